>>> hw/rtl/afs_pkg.sv
// afs_pkg: shared types and constants for the animation frame stepper.
// Used by afs_ctrl, afs_datapath and animation_frame_stepper_unit; no dependencies.
`default_nettype none

package afs_pkg;

    localparam int POS_BITS  = 16;
    localparam int STEP_BITS = 16;
    localparam int RATE_BITS = 8;
    localparam int CMD_BITS  = 2;
    localparam int RND_BITS  = 10;
    localparam int PROD_BITS = STEP_BITS + RATE_BITS;

    // pos + step*rate, one carry bit over the wider operand
    localparam int SUM_BITS  = ((POS_BITS > PROD_BITS) ? POS_BITS : PROD_BITS) + 1;
    // divisor holds up to 2*frame_count - 1
    localparam int DIV_BITS  = POS_BITS + 1;
    // remainder unit retires one dividend bit per cycle
    localparam int MOD_STEPS = SUM_BITS;
    localparam int CNT_BITS  = $clog2(MOD_STEPS);

    localparam logic [RND_BITS-1:0] RND_THRESHOLD = 10'h3EF;

    localparam logic [CMD_BITS-1:0] CMD_RANDOM      = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_START       = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_HOLD        = 2'd2;
    localparam logic [CMD_BITS-1:0] CMD_HOLD_AT_END = 2'd3;

    typedef struct packed {
        logic [POS_BITS-1:0]  frame_position;
        logic                 blink_enable;
        logic                 sequence_active;
        logic                 play_reverse;
        logic [POS_BITS-1:0]  frame_count;
        logic [STEP_BITS-1:0] advance_step;
        logic [RATE_BITS-1:0] update_rate;
        logic [CMD_BITS-1:0]  blink_command;
        logic [RND_BITS-1:0]  random_draw;
    } t_step_in;

    typedef struct packed {
        logic [POS_BITS-1:0] new_position;
        logic                new_active;
        logic                new_reverse;
    } t_step_out;

    typedef struct packed {
        logic load;
        logic mul;
        logic pre;
        logic mod_step;
        logic post;
    } t_dp_cmd;

    typedef struct packed {
        logic need_mod;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> hw/rtl/afs_datapath.sv
// afs_datapath: operand registers, step multiplier, mode logic and a
// bit-serial remainder unit. Depends on afs_pkg; driven by afs_ctrl.
`default_nettype none

module afs_datapath (
    input  wire logic              i_clk,
    input  wire afs_pkg::t_dp_cmd  i_cmd,
    input  wire afs_pkg::t_step_in i_item,
    output afs_pkg::t_dp_stat      o_stat,
    output afs_pkg::t_step_out     o_result
);

    localparam int P = afs_pkg::POS_BITS;
    localparam int S = afs_pkg::SUM_BITS;
    localparam int B = afs_pkg::DIV_BITS;

    typedef enum logic [1:0] {
        K_NONE,
        K_FWD,
        K_BACK,
        K_PP
    } t_mod_kind;

    afs_pkg::t_step_in             r_in;
    logic [afs_pkg::PROD_BITS-1:0] r_prod;
    logic [S-1:0]                  r_x, n_x;
    logic [S-1:0]                  r_a, n_a;
    logic [B-1:0]                  r_b, n_b;
    logic [B-1:0]                  r_rem;
    logic                          r_act, n_act;
    logic                          r_rev, n_rev;
    t_mod_kind                     r_kind, n_kind;
    afs_pkg::t_step_out            r_out, n_out;

    logic [S-1:0] pos_w, n_w, d_w, n2_w, sum, diff_mag, mag;
    logic         pos_ge_d, start;
    logic [B:0]   shifted;
    logic [B-1:0] rem_next, v;

    always_comb begin
        pos_w    = S'(r_in.frame_position);
        n_w      = S'(r_in.frame_count);
        d_w      = S'(r_prod);
        n2_w     = S'({r_in.frame_count, 1'b0});
        sum      = pos_w + d_w;
        pos_ge_d = pos_w >= d_w;
        diff_mag = pos_ge_d ? (pos_w - d_w) : (d_w - pos_w);
        mag      = r_in.play_reverse ? diff_mag : sum;
        start    = 1'b0;

        n_act  = r_in.sequence_active;
        n_rev  = r_in.play_reverse;
        n_kind = K_NONE;
        n_x    = pos_w;
        n_a    = sum;
        n_b    = B'(r_in.frame_count);

        if (r_in.blink_enable) begin
            if (!r_in.sequence_active) begin
                if (r_in.blink_command == afs_pkg::CMD_RANDOM) begin
                    start = r_in.random_draw > afs_pkg::RND_THRESHOLD;
                end else begin
                    start = r_in.blink_command != afs_pkg::CMD_HOLD;
                end
                if (start) begin
                    n_rev = 1'b0;
                    n_act = 1'b1;
                end
            end else if (!r_in.play_reverse) begin
                n_x = sum;
                if (sum >= n_w) begin
                    if (r_in.blink_command == afs_pkg::CMD_HOLD_AT_END) begin
                        n_x = (n_w == '0) ? '0 : (n_w - S'(1));
                    end else if (sum >= n2_w) begin
                        // reflection lands below frame 0: sequence over
                        n_x   = '0;
                        n_rev = 1'b0;
                        n_act = 1'b0;
                    end else begin
                        n_x   = n2_w - sum - S'(1);
                        n_rev = 1'b1;
                    end
                end
            end else begin
                if (!pos_ge_d) begin
                    n_x   = '0;
                    n_rev = 1'b0;
                    n_act = 1'b0;
                end else begin
                    n_x = diff_mag;
                end
            end
        end else if (r_in.frame_count == '0) begin
            n_x = '0;
        end else if (r_in.sequence_active) begin
            // ping-pong: bounce off frame 0 first, then fold into [0, 2n-1)
            if (r_in.play_reverse && !pos_ge_d) begin
                n_rev = 1'b0;
            end
            n_x = mag;
            if (mag >= n_w) begin
                n_kind = K_PP;
                n_a    = mag - S'(1);
                n_b    = B'(n2_w - S'(1));
            end
        end else if (!r_in.play_reverse) begin
            n_x = sum;
            if (sum >= n_w) begin
                n_kind = K_FWD;
            end
        end else begin
            if (pos_ge_d) begin
                n_x = diff_mag;
            end else begin
                // floor mod of -k is n-1-((k-1) mod n)
                n_kind = K_BACK;
                n_a    = diff_mag - S'(1);
            end
        end
    end

    always_comb begin
        shifted  = {r_rem, r_a[S-1]};
        rem_next = (shifted >= {1'b0, r_b}) ? B'(shifted - {1'b0, r_b}) : B'(shifted);
    end

    always_comb begin
        v     = r_rem + B'(1);
        n_out = r_out;
        n_out.new_active  = r_act;
        n_out.new_reverse = r_rev;
        case (r_kind)
            K_NONE: begin
                n_out.new_position = P'(r_x);
            end
            K_FWD: begin
                n_out.new_position = P'(r_rem);
            end
            K_BACK: begin
                n_out.new_position = P'(B'(r_in.frame_count) - B'(1) - r_rem);
            end
            K_PP: begin
                if (v >= B'(r_in.frame_count)) begin
                    n_out.new_position = P'(B'({r_in.frame_count, 1'b0}) - B'(1) - v);
                    n_out.new_reverse  = 1'b1;
                end else begin
                    n_out.new_position = P'(v);
                    n_out.new_reverse  = 1'b0;
                end
            end
            default: begin
                n_out.new_position = P'(r_x);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_item;
        end
        if (i_cmd.mul) begin
            r_prod <= afs_pkg::PROD_BITS'(r_in.advance_step)
                    * afs_pkg::PROD_BITS'(r_in.update_rate);
        end
        if (i_cmd.pre) begin
            r_x    <= n_x;
            r_a    <= n_a;
            r_b    <= n_b;
            r_act  <= n_act;
            r_rev  <= n_rev;
            r_kind <= n_kind;
            r_rem  <= '0;
        end
        if (i_cmd.mod_step) begin
            r_rem <= rem_next;
            r_a   <= {r_a[S-2:0], 1'b0};
        end
        if (i_cmd.post) begin
            r_out <= n_out;
        end
    end

    assign o_stat.need_mod = (r_kind != K_NONE);
    assign o_result        = r_out;

endmodule

`default_nettype wire

>>> hw/rtl/afs_ctrl.sv
// afs_ctrl: sequencing state machine for the frame stepper.
// Depends on afs_pkg; issues commands to afs_datapath.
`default_nettype none

module afs_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire afs_pkg::t_dp_stat i_stat,
    output afs_pkg::t_dp_cmd      o_cmd,
    output logic                  o_busy,
    output logic                  o_done
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_PRE,
        S_MOD,
        S_POST
    } t_state;

    t_state                        r_state, n_state;
    logic [afs_pkg::CNT_BITS-1:0]  r_cnt, n_cnt;
    logic                          r_busy, n_busy;
    logic                          r_done, n_done;
    logic                          accept;

    assign accept = i_start && !r_busy;

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = (r_state == S_IDLE) && accept;
        o_cmd.mul      = (r_state == S_MUL);
        o_cmd.pre      = (r_state == S_PRE);
        o_cmd.mod_step = (r_state == S_MOD);
        o_cmd.post     = (r_state == S_POST);
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_MUL;
                    n_busy  = 1'b1;
                end
            end
            S_MUL: begin
                n_state = S_PRE;
            end
            S_PRE: begin
                n_state = S_MOD;
                n_cnt   = afs_pkg::CNT_BITS'(afs_pkg::MOD_STEPS - 1);
            end
            S_MOD: begin
                // no wrap needed: skip the remainder passes
                if (!i_stat.need_mod || r_cnt == '0) begin
                    n_state = S_POST;
                end else begin
                    n_cnt = r_cnt - afs_pkg::CNT_BITS'(1);
                end
            end
            S_POST: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
                n_done  = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_busy  <= n_busy;
            r_done  <= n_done;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;

endmodule

`default_nettype wire

>>> hw/rtl/animation_frame_stepper_unit.sv
// animation_frame_stepper_unit: top level of the animation frame stepper.
// Depends on afs_pkg, afs_ctrl and afs_datapath.
//
//   channel  | handshake         | payload
//   ---------+-------------------+--------------------------
//   request  | start / busy      | i_data  (afs_pkg::t_step_in)
//   result   | o_done (1 cycle)  | o_data  (afs_pkg::t_step_out)
//
// A request passes through multiply, mode logic, then a one-bit-per-cycle
// remainder unit, whose passes are skipped when no wrap is needed.
// o_done pulses for one cycle; o_data holds until the next result.
// busy is high from acceptance until the result cycle; a new request can
// be taken in the same cycle that o_done is high. Sync active-low reset
// clears the controller only. The receiver cannot stall.
`default_nettype none

module animation_frame_stepper_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire afs_pkg::t_step_in  i_data,
    output logic                    o_done,
    output afs_pkg::t_step_out      o_data
);

    afs_pkg::t_dp_cmd  cmd;
    afs_pkg::t_dp_stat stat;

    afs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    afs_datapath u_datapath (
        .i_clk    (i_clk),
        .i_cmd    (cmd),
        .i_item   (i_data),
        .o_stat   (stat),
        .o_result (o_data)
    );

endmodule

`default_nettype wire
